### design/qmlt_pkg.sv
// qmlt_pkg: shared types and constants for the queued message log transmitter
// no dependencies; imported by every module of the block
package qmlt_pkg;

  localparam int unsigned NumMessages   = 8;
  localparam int unsigned MessageLength = 32;
  localparam int unsigned RowW          = 3;
  localparam int unsigned PosW          = 5;
  localparam int unsigned AddrW         = RowW + PosW;
  localparam int unsigned CountOutW     = 4;

  typedef enum logic [1:0] {
    FuncLoad    = 2'd0,
    FuncRequest = 2'd1,
    FuncSend    = 2'd2,
    FuncTick    = 2'd3
  } func_e;

  typedef struct packed {
    logic [CountOutW-1:0] queued_count;
    logic                 tx_enabled;
    logic [7:0]           char_out;
    logic                 slot_granted;
    logic                 char_valid;
    logic                 last_char;
  } result_t;

  typedef struct packed {
    logic             en;
    logic [AddrW-1:0] addr;
    logic [7:0]       data;
  } mem_wr_t;

  typedef struct packed {
    logic [AddrW-1:0] addr_a;
    logic [AddrW-1:0] addr_b;
  } mem_rd_t;

endpackage

### design/qmlt_msg_store.sv
// qmlt_msg_store: message byte table with per-entry valid bits and two registered reads
// depends on qmlt_pkg
module qmlt_msg_store (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  qmlt_pkg::mem_wr_t wr_i,
  input  qmlt_pkg::mem_rd_t rd_i,
  output logic [7:0]        byte_a_o,
  output logic [7:0]        byte_b_o
);
  import qmlt_pkg::*;

  localparam int unsigned Depth = NumMessages * MessageLength;

  logic [7:0]       mem [Depth];
  logic [Depth-1:0] valid_q;
  logic [7:0]       rd_a_q, rd_b_q;
  logic             hit_a_q, hit_b_q;
  logic             byp_a, byp_b;

  assign byp_a = wr_i.en && (wr_i.addr == rd_i.addr_a);
  assign byp_b = wr_i.en && (wr_i.addr == rd_i.addr_b);

  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      mem[wr_i.addr] <= wr_i.data;
    end
    rd_a_q <= byp_a ? wr_i.data : mem[rd_i.addr_a];
    rd_b_q <= byp_b ? wr_i.data : mem[rd_i.addr_b];
  end

  // entries never written read as zero
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
      hit_a_q <= 1'b0;
      hit_b_q <= 1'b0;
    end else begin
      if (wr_i.en) begin
        valid_q[wr_i.addr] <= 1'b1;
      end
      hit_a_q <= byp_a || valid_q[rd_i.addr_a];
      hit_b_q <= byp_b || valid_q[rd_i.addr_b];
    end
  end

  assign byte_a_o = hit_a_q ? rd_a_q : 8'd0;
  assign byte_b_o = hit_b_q ? rd_b_q : 8'd0;

endmodule

### design/qmlt_ctrl.sv
// qmlt_ctrl: id queue, reservation, send sequencing and result formation
// depends on qmlt_pkg; reads prefetched bytes from qmlt_msg_store
module qmlt_ctrl #(
  parameter int unsigned QUEUE_DEPTH = 8
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          fire_i,
  input  qmlt_pkg::func_e               func_i,
  input  logic [qmlt_pkg::RowW-1:0]     msg_id_i,
  input  logic [qmlt_pkg::PosW-1:0]     char_index_i,
  input  logic [7:0]                    char_byte_i,
  input  logic [7:0]                    byte_a_i,
  input  logic [7:0]                    byte_b_i,
  output qmlt_pkg::mem_wr_t             wr_o,
  output qmlt_pkg::mem_rd_t             rd_o,
  output qmlt_pkg::result_t             res_o
);
  import qmlt_pkg::*;

  localparam int unsigned PtrW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned CntW = $clog2(QUEUE_DEPTH + 1);
  localparam logic [PtrW-1:0] PtrLast = PtrW'(QUEUE_DEPTH - 1);
  localparam logic [CntW-1:0] CntFull = CntW'(QUEUE_DEPTH);
  localparam logic [PosW-1:0] PosLast = PosW'(MessageLength - 1);

  logic [RowW-1:0] fifo_q [QUEUE_DEPTH];
  logic [PtrW-1:0] head_q, head_d, tail_q, tail_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            pend_q, pend_d;
  logic            send_q, send_d;
  logic            tx_q, tx_d;
  logic [RowW-1:0] cur_q, cur_d;
  logic [PosW-1:0] pos_q, pos_d;
  logic            fifo_we;
  logic [PosW-1:0] pos_eff;
  logic            full;
  logic            last;
  logic [RowW-1:0] head_id;
  logic [RowW-1:0] pf_row;
  logic [PosW-1:0] pf_pos;

  assign full = (cnt_q == CntFull);

  always_comb begin
    head_d  = head_q;
    tail_d  = tail_q;
    cnt_d   = cnt_q;
    pend_d  = pend_q;
    send_d  = send_q;
    tx_d    = tx_q;
    cur_d   = cur_q;
    pos_d   = pos_q;
    fifo_we = 1'b0;
    wr_o    = '0;
    res_o   = '0;
    pos_eff = send_q ? pos_q : '0;
    last    = (pos_eff == PosLast) || (byte_b_i == 8'd0);
    if (fire_i) begin
      case (func_i)
        FuncLoad: begin
          wr_o.en   = (32'(msg_id_i) < NumMessages) && (32'(char_index_i) < MessageLength);
          wr_o.addr = {msg_id_i, char_index_i};
          wr_o.data = char_byte_i;
        end
        FuncRequest: begin
          if (!full && !pend_q) begin
            pend_d = 1'b1;
            res_o.slot_granted = 1'b1;
          end
        end
        FuncSend: begin
          if (pend_q) begin
            if (!full) begin
              fifo_we = 1'b1;
              tail_d  = (tail_q == PtrLast) ? '0 : tail_q + 1'b1;
              cnt_d   = cnt_q + 1'b1;
            end
            pend_d = 1'b0;
          end
          tx_d = 1'b1;
        end
        FuncTick: begin
          if (tx_q) begin
            if (send_q || (cnt_q != '0)) begin
              if (!send_q) begin
                cur_d  = fifo_q[head_q];
                head_d = (head_q == PtrLast) ? '0 : head_q + 1'b1;
                cnt_d  = cnt_q - 1'b1;
              end
              res_o.char_valid = 1'b1;
              res_o.char_out   = byte_a_i;
              res_o.last_char  = last;
              send_d = !last;
              pos_d  = last ? '0 : pos_eff + 1'b1;
            end else begin
              tx_d = 1'b0;
            end
          end
        end
        default: begin
        end
      endcase
    end
    res_o.tx_enabled   = tx_d;
    res_o.queued_count = CountOutW'(cnt_d);
  end

  // prefetch the two bytes the next tick needs, from the state after this cycle
  assign head_id = (fifo_we && (tail_q == head_d)) ? msg_id_i : fifo_q[head_d];
  assign pf_row  = send_d ? cur_d : head_id;
  assign pf_pos  = send_d ? pos_d : '0;
  assign rd_o.addr_a = {pf_row, pf_pos};
  assign rd_o.addr_b = {pf_row, PosW'(pf_pos + 1'b1)};

  always_ff @(posedge clk_i) begin
    if (fifo_we) begin
      fifo_q[tail_q] <= msg_id_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q <= '0;
      tail_q <= '0;
      cnt_q  <= '0;
      pend_q <= 1'b0;
      send_q <= 1'b0;
      tx_q   <= 1'b0;
      cur_q  <= '0;
      pos_q  <= '0;
    end else begin
      head_q <= head_d;
      tail_q <= tail_d;
      cnt_q  <= cnt_d;
      pend_q <= pend_d;
      send_q <= send_d;
      tx_q   <= tx_d;
      cur_q  <= cur_d;
      pos_q  <= pos_d;
    end
  end

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CntFull)
    else $error("queue count above depth");

  a_send_needs_tx: assert property (@(posedge clk_i) disable iff (!rst_ni)
    send_q |-> tx_q)
    else $error("message under way with transmitter disabled");

  a_pend_has_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_q |-> (cnt_q < CntFull))
    else $error("reservation held on a full queue");

  a_pos_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !send_q |-> (pos_q == '0))
    else $error("character position left nonzero after message end");

endmodule

### design/qmlt_out_buf.sv
// qmlt_out_buf: two-entry output register with skid stage for result items
// depends on qmlt_pkg
module qmlt_out_buf (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  qmlt_pkg::result_t in_data_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output qmlt_pkg::result_t out_data_o
);
  import qmlt_pkg::*;

  logic    main_vld_q, skid_vld_q;
  result_t main_q, skid_q;
  logic    in_fire;

  assign in_ready_o  = !skid_vld_q;
  assign in_fire     = in_valid_i && in_ready_o;
  assign out_valid_o = main_vld_q;
  assign out_data_o  = main_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      main_vld_q <= 1'b0;
      skid_vld_q <= 1'b0;
    end else if (!main_vld_q || out_ready_i) begin
      main_vld_q <= skid_vld_q || in_fire;
      skid_vld_q <= 1'b0;
    end else if (in_fire) begin
      skid_vld_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!main_vld_q || out_ready_i) begin
      main_q <= skid_vld_q ? skid_q : in_data_i;
    end else if (in_fire) begin
      skid_q <= in_data_i;
    end
  end

  a_skid_behind_main: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_vld_q |-> main_vld_q)
    else $error("skid entry held while output register empty");

endmodule

### design/queued_message_log_transmitter_top.sv
// queued_message_log_transmitter_top: top level of the queued message log transmitter
// depends on qmlt_pkg, qmlt_msg_store, qmlt_ctrl, qmlt_out_buf
//
// usage: every request on s_axis carries a function in tuser (load byte, request slot,
// send message, transmitter ready tick) and its operands in tdata. load writes one byte
// of the message table; request reserves a queue slot; send queues a message number
// and enables the transmitter; tick emits the next character, or disables it if none.
// every accepted request yields exactly one result on m_axis: tdata holds the reserve
// flag, the character, the enable and the queue count; tuser flags a character, tlast
// marks the last character of a message.
// output: m_axis_tvalid rises in the cycle after acceptance when the output is free.
// throughput: one request per cycle while s_axis_tready is high; a tick's two bytes
// are prefetched from the message table, from the state left by the previous request.
// reset: the message table reads as all zero, the queue is empty, no reservation is
// held and the transmitter is disabled; there is no clearing pass.
// stall: results sit in a two-entry output buffer; s_axis_tready drops only when both
// entries are full and returns in the cycle after m_axis takes a result.
module queued_message_log_transmitter_top #(
  parameter int unsigned QUEUE_DEPTH = 8
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,   // msg_id[2:0], char_index[7:3], char_byte[15:8]
  input  logic [1:0]  s_axis_tuser,   // func[1:0]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,   // slot_granted[0], char_out[8:1],
                                      // tx_enabled[9], queued_count[13:10], zero[15:14]
  output logic        m_axis_tuser,   // char_valid
  output logic        m_axis_tlast    // last_char
);
  import qmlt_pkg::*;

  logic    fire;
  func_e   func;
  mem_wr_t wr;
  mem_rd_t rd;
  logic [7:0] byte_a, byte_b;
  result_t res, out_res;

  assign fire = s_axis_tvalid && s_axis_tready;
  assign func = func_e'(s_axis_tuser);

  qmlt_msg_store u_store (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .wr_i     (wr),
    .rd_i     (rd),
    .byte_a_o (byte_a),
    .byte_b_o (byte_b)
  );

  qmlt_ctrl #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .fire_i       (fire),
    .func_i       (func),
    .msg_id_i     (s_axis_tdata[2:0]),
    .char_index_i (s_axis_tdata[7:3]),
    .char_byte_i  (s_axis_tdata[15:8]),
    .byte_a_i     (byte_a),
    .byte_b_i     (byte_b),
    .wr_o         (wr),
    .rd_o         (rd),
    .res_o        (res)
  );

  qmlt_out_buf u_out (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .in_data_i   (res),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_data_o  (out_res)
  );

  assign m_axis_tdata = {2'b00, out_res.queued_count, out_res.tx_enabled,
                         out_res.char_out, out_res.slot_granted};
  assign m_axis_tuser = out_res.char_valid;
  assign m_axis_tlast = out_res.last_char;

endmodule

### test/qmlt_result_check.sv
// qmlt_result_check: watches both streams of the queued message log transmitter,
// predicts one result per accepted request and compares them in order
// depends on qmlt_pkg
module qmlt_result_check (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  input  logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,
  input  logic [1:0]  s_axis_tuser,
  input  logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  input  logic [15:0] m_axis_tdata,
  input  logic        m_axis_tuser,
  input  logic        m_axis_tlast,
  output int          fail_count_o,
  output int          awaiting_o
);
  import qmlt_pkg::*;

  localparam int unsigned QueueDepth = 8;

  logic [7:0]      msg_table [NumMessages*MessageLength];
  logic [RowW-1:0] id_queue [QueueDepth];
  int unsigned     q_head;
  int unsigned     q_tail;
  int unsigned     q_count;
  logic            slot_reserved;
  logic            msg_in_flight;
  logic            tx_on;
  logic [RowW-1:0] active_msg;
  int unsigned     char_pos;
  int              errors;
  result_t         expected_results[$];

  function automatic logic [7:0] row_byte(input logic [RowW-1:0] row, input int unsigned pos);
    if (pos >= MessageLength) begin
      return 8'h00;
    end
    return msg_table[row * MessageLength + pos];
  endfunction

  task automatic clear_log_state();
    foreach (msg_table[i]) msg_table[i] = 8'h00;
    foreach (id_queue[i]) id_queue[i] = '0;
    q_head        = 0;
    q_tail        = 0;
    q_count       = 0;
    slot_reserved = 1'b0;
    msg_in_flight = 1'b0;
    tx_on         = 1'b0;
    active_msg    = '0;
    char_pos      = 0;
    errors        = 0;
    expected_results.delete();
  endtask

  task automatic predict_log_step(input func_e fn, input logic [2:0] id,
                                  input logic [4:0] idx, input logic [7:0] value);
    result_t r;
    r = '0;
    case (fn)
      FuncLoad: begin
        msg_table[{id, idx}] = value;
      end
      FuncRequest: begin
        if (q_count < QueueDepth && !slot_reserved) begin
          slot_reserved  = 1'b1;
          r.slot_granted = 1'b1;
        end
      end
      FuncSend: begin
        if (slot_reserved) begin
          if (q_count < QueueDepth) begin
            id_queue[q_tail] = id;
            q_tail           = (q_tail + 1) % QueueDepth;
            q_count++;
          end
          slot_reserved = 1'b0;
        end
        tx_on = 1'b1;
      end
      FuncTick: begin
        if (tx_on) begin
          if (msg_in_flight || q_count > 0) begin
            if (!msg_in_flight) begin
              active_msg    = id_queue[q_head];
              q_head        = (q_head + 1) % QueueDepth;
              q_count--;
              char_pos      = 0;
              msg_in_flight = 1'b1;
            end
            r.char_out   = row_byte(active_msg, char_pos);
            r.char_valid = 1'b1;
            char_pos++;
            // message ends at the row end or before a zero byte
            if (char_pos >= MessageLength || row_byte(active_msg, char_pos) == 8'h00) begin
              r.last_char   = 1'b1;
              msg_in_flight = 1'b0;
              char_pos      = 0;
            end
          end else begin
            tx_on = 1'b0;
          end
        end
      end
      default: ;
    endcase
    r.tx_enabled   = tx_on;
    r.queued_count = q_count[CountOutW-1:0];
    expected_results.push_back(r);
  endtask

  task automatic compare_field(input string name, input int unsigned want,
                               input int unsigned got);
    if (want != got) begin
      errors++;
      $display("%0t: %s mismatch, expected %0h actual %0h", $time, name, want, got);
    end
  endtask

  task automatic check_log_result(input logic [15:0] data, input logic valid_flag,
                                  input logic last_flag);
    result_t want;
    if (expected_results.size() == 0) begin
      errors++;
      $display("%0t: unexpected result, expected none actual tdata %h tuser %b tlast %b",
               $time, data, valid_flag, last_flag);
    end else begin
      want = expected_results.pop_front();
      compare_field("slot_granted", want.slot_granted, data[0]);
      compare_field("char_out", want.char_out, data[8:1]);
      compare_field("tx_enabled", want.tx_enabled, data[9]);
      compare_field("queued_count", want.queued_count, data[13:10]);
      compare_field("char_valid", want.char_valid, valid_flag);
      compare_field("last_char", want.last_char, last_flag);
      compare_field("tdata padding", 0, data[15:14]);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clear_log_state();
      fail_count_o <= 0;
      awaiting_o   <= 0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        check_log_result(m_axis_tdata, m_axis_tuser, m_axis_tlast);
      end
      if (s_axis_tvalid && s_axis_tready) begin
        predict_log_step(func_e'(s_axis_tuser), s_axis_tdata[2:0], s_axis_tdata[7:3],
                         s_axis_tdata[15:8]);
      end
      fail_count_o <= errors;
      awaiting_o   <= expected_results.size();
    end
  end

endmodule

### test/queued_message_log_transmitter_top_tb.sv
// queued_message_log_transmitter_top_tb: drives load, request, send and tick requests
// into the transmitter with random gaps and output stalls, and gives the verdict
// depends on qmlt_pkg, queued_message_log_transmitter_top and qmlt_result_check
module queued_message_log_transmitter_top_tb;
  import qmlt_pkg::*;

  logic        clk_i         = 1'b0;
  logic        rst_ni        = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [15:0] s_axis_tdata  = '0;
  logic [1:0]  s_axis_tuser  = FuncLoad;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [15:0] m_axis_tdata;
  logic        m_axis_tuser;
  logic        m_axis_tlast;
  int          fail_count;
  int          awaiting;
  int          sent_count    = 0;

  queued_message_log_transmitter_top u_top (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser),
    .m_axis_tlast (m_axis_tlast)
  );

  qmlt_result_check u_result_check (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser),
    .m_axis_tlast (m_axis_tlast),
    .fail_count_o (fail_count),
    .awaiting_o   (awaiting)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
  end

  initial begin
    #5000000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // every fourth stretch of 80 transfers runs without idling
  function automatic bit no_idle_phase(input int n);
    return (n / 80) % 4 == 3;
  endfunction

  task automatic issue_request(input func_e fn, input logic [2:0] id,
                               input logic [4:0] idx, input logic [7:0] value);
    int gap;
    gap = no_idle_phase(sent_count) ? 0 : $urandom_range(0, 16);
    if (gap != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= fn;
    s_axis_tdata  <= {value, idx, id};
    do @(posedge clk_i); while (!s_axis_tready);
    sent_count++;
  endtask

  task automatic issue_noise(input func_e fn);
    issue_request(fn, 3'($urandom_range(0, 7)), 5'($urandom_range(0, 31)),
                  8'($urandom_range(0, 255)));
  endtask

  task automatic load_message(input logic [2:0] id);
    int pick;
    int len;
    pick = $urandom_range(0, 9);
    len  = (pick == 0) ? 32 : (pick == 1) ? 31 : $urandom_range(0, 8);
    for (int i = 0; i < len; i++) begin
      issue_request(FuncLoad, id, 5'(i),
                    ($urandom_range(0, 15) == 0) ? 8'h00 : 8'($urandom_range(1, 255)));
    end
    if (len < 32) begin
      issue_request(FuncLoad, id, 5'(len), 8'h00);
    end
  endtask

  task automatic queue_messages(input int n);
    for (int i = 0; i < n; i++) begin
      issue_noise(FuncRequest);
      if ($urandom_range(0, 9) == 0) begin
        issue_noise(FuncRequest);
      end
      if ($urandom_range(0, 14) != 0) begin
        issue_noise(FuncSend);
      end
    end
  endtask

  initial begin
    int pick;
    int n;
    @(posedge rst_ni);
    // tick while disabled, then short rows with extreme bytes and a tail past the zero
    issue_request(FuncTick, 3'd5, 5'd17, 8'hA5);
    issue_request(FuncLoad, 3'd7, 5'd0, 8'hFF);
    issue_request(FuncLoad, 3'd7, 5'd1, 8'h80);
    issue_request(FuncLoad, 3'd7, 5'd31, 8'h55);
    issue_request(FuncLoad, 3'd2, 5'd0, 8'h01);
    // send without reservation enables, empty queue tick disables
    issue_request(FuncSend, 3'd0, 5'd0, 8'h00);
    issue_request(FuncTick, 3'd7, 5'd31, 8'hFF);
    issue_request(FuncRequest, 3'd0, 5'd0, 8'h00);
    issue_request(FuncRequest, 3'd7, 5'd31, 8'hFF);
    issue_request(FuncSend, 3'd7, 5'd0, 8'h00);
    issue_request(FuncSend, 3'd3, 5'd0, 8'h00);
    issue_request(FuncRequest, 3'd0, 5'd0, 8'h00);
    issue_request(FuncSend, 3'd0, 5'd0, 8'h00);
    issue_request(FuncRequest, 3'd0, 5'd0, 8'h00);
    issue_request(FuncSend, 3'd2, 5'd0, 8'h00);
    // two chars of row 7, empty row 0, one char of row 2, disable, ignored tick
    repeat (6) issue_noise(FuncTick);

    while (sent_count < 1300) begin
      pick = $urandom_range(0, 99);
      if (pick < 15) begin
        load_message(3'($urandom_range(0, 7)));
      end else if (pick < 45) begin
        n = ($urandom_range(0, 7) == 0) ? 9 : $urandom_range(1, 3);
        queue_messages(n);
      end else if (pick < 85) begin
        n = $urandom_range(1, 24);
        repeat (n) issue_noise(FuncTick);
      end else begin
        n = $urandom_range(1, 4);
        repeat (n) issue_noise(func_e'($urandom_range(0, 3)));
      end
    end
    s_axis_tvalid <= 1'b0;

    do @(posedge clk_i); while (awaiting != 0);
    repeat (4) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  initial begin
    int stall;
    int taken;
    taken = 0;
    @(posedge rst_ni);
    forever begin
      stall = no_idle_phase(taken) ? 0 : $urandom_range(0, 16);
      if (stall != 0) begin
        m_axis_tready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk_i); while (!m_axis_tvalid);
      taken++;
    end
  end

endmodule

### queued_message_log_transmitter_top.f
design/qmlt_pkg.sv
design/qmlt_msg_store.sv
design/qmlt_ctrl.sv
design/qmlt_out_buf.sv
design/queued_message_log_transmitter_top.sv
test/qmlt_result_check.sv
test/queued_message_log_transmitter_top_tb.sv
